[rtl/rdm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package rdm_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int COEF_WIDTH  = 48;
  localparam int TOL_WIDTH   = 16;
  localparam int LIM_WIDTH   = 8;
  localparam int CFG_IDX_W   = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_K1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_K2  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_K3  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIM = 3'd4;

  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd17;
  localparam logic [LIM_WIDTH-1:0] LIM_RESET = 8'd50;

  // Result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO      = 2'd1;
  localparam logic [1:0] STAT_NOCONVERGE = 2'd2;

  typedef struct packed {
    logic                          req_type;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } rdm_req_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] result_x;
    logic signed [COORD_WIDTH-1:0] result_y;
    logic [1:0]                    status;
  } rdm_result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQX, ST_SQY, ST_R4, ST_R6, ST_K1, ST_K2, ST_K3, ST_CHKS,
    ST_FWDX, ST_FWDY, ST_DIVX, ST_DIVY, ST_CONV, ST_DONE
  } rdm_state_t;

  // Multiplier operand selection
  typedef enum logic [3:0] {
    MOP_XX, MOP_YY, MOP_R4, MOP_R6, MOP_K1, MOP_K2, MOP_K3, MOP_FX, MOP_FY
  } rdm_mop_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    logic     mul_wb;
    rdm_mop_t mop;
    logic     div_start;
    logic     div_wb;
    logic     div_y;
    logic     step;
    logic     set_zero;
  } rdm_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic scale_zero;
    logic inverse;
    logic converged;
    logic last_pass;
    logic lim_zero;
  } rdm_stat_t;

endpackage
`default_nettype wire

[rtl/rdm_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// Signed 64x64 multiply, shift right toward zero, saturate to 64 bits.
// Four 32x32 partial products accumulated in turn, then a finalize step.
module rdm_mul #(
  parameter int COEF_WIDTH = rdm_pkg::COEF_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  input  wire logic               frac_coef,
  output logic                    done,
  output logic signed [63:0]      prod
);
  localparam int PF = rdm_pkg::COORD_WIDTH - 8;
  localparam int CF = COEF_WIDTH - 8;

  logic [63:0]  ua, ub;
  logic         neg, fsel, run, fin;
  logic [1:0]   step;
  logic [127:0] acc;
  logic [31:0]  ah, bh;
  logic [63:0]  pp;
  logic [127:0] pp_w, sh_val;
  logic [63:0]  res;
  logic         over;
  logic signed [63:0] sat_val;

  // Partial product for the current step
  always_comb begin
    ah = step[1] ? ua[63:32] : ua[31:0];
    bh = step[0] ? ub[63:32] : ub[31:0];
    pp = {32'd0, ah} * {32'd0, bh};
    case (step)
      2'd0:    pp_w = {64'd0, pp};
      2'd3:    pp_w = {pp, 64'd0};
      default: pp_w = {32'd0, pp, 32'd0};
    endcase
  end

  // Truncate, shift, saturate
  always_comb begin
    sh_val = fsel ? (acc >> CF) : (acc >> PF);
    res    = sh_val[63:0];
    over   = |sh_val[127:64];
    if (!neg) begin
      sat_val = (over || res[63]) ? 64'sh7fff_ffff_ffff_ffff : $signed(res);
    end else begin
      if (over || (res[63] && (|res[62:0]))) sat_val = 64'sh8000_0000_0000_0000;
      else sat_val = $signed(~res + 64'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ua   <= a[63] ? (~a + 64'd1) : a;
        ub   <= b[63] ? (~b + 64'd1) : b;
        neg  <= a[63] ^ b[63];
        fsel <= frac_coef;
        acc  <= '0;
        step <= 2'd0;
        run  <= 1'b1;
      end else if (run) begin
        acc  <= acc + pp_w;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        prod <= sat_val;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/rdm_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: (num << CF) / den, one quotient bit a cycle,
// truncated toward zero, saturated to the coordinate range.
module rdm_div #(
  parameter int COEF_WIDTH = rdm_pkg::COEF_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic signed [rdm_pkg::COORD_WIDTH-1:0] num,
  input  wire logic signed [63:0]                    den,
  output logic                                       done,
  output logic signed [rdm_pkg::COORD_WIDTH-1:0]     quo
);
  localparam int CW   = rdm_pkg::COORD_WIDTH;
  localparam int CF   = COEF_WIDTH - 8;
  localparam int N    = CW + CF;
  localparam int CNTW = $clog2(N + 1);
  localparam logic [CW+1:0] QLIM = (CW+2)'(1) << CW;
  localparam logic [CW+1:0] QMAX = ((CW+2)'(1) << (CW - 1)) - (CW+2)'(1);
  localparam logic [CW+1:0] QMIN = (CW+2)'(1) << (CW - 1);

  logic [CW-1:0]   nsh;
  logic [63:0]     ud, rem;
  logic [CW+1:0]   q, qn;
  logic            big, neg, run, fin;
  logic [CNTW-1:0] cnt;
  logic [64:0]     rem_sh;
  logic            ge;
  logic [CW-1:0]   sat_q;

  always_comb begin
    rem_sh = {rem, nsh[CW-1]};
    ge     = rem_sh >= {1'b0, ud};
    qn     = {q[CW:0], ge};
    if (!neg) sat_q = (big || q > QMAX) ? QMAX[CW-1:0] : q[CW-1:0];
    else sat_q = (big || q > QMIN) ? QMIN[CW-1:0] : (~q[CW-1:0] + CW'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        nsh <= num[CW-1] ? (~num + CW'(1)) : num;
        ud  <= den[63] ? (~den + 64'd1) : den;
        neg <= num[CW-1] ^ den[63];
        rem <= '0;
        q   <= '0;
        big <= 1'b0;
        cnt <= CNTW'(N);
        run <= 1'b1;
      end else if (run) begin
        nsh <= nsh << 1;
        rem <= ge ? 64'(rem_sh - {1'b0, ud}) : rem_sh[63:0];
        if (!big) begin
          q <= qn;
          if (qn > QLIM) big <= 1'b1;
        end
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
        quo  <= $signed(sat_q);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/rdm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// Registers, operand selection and writeback around the shared
// multiplier and divider.
module rdm_datapath #(
  parameter int COEF_WIDTH = rdm_pkg::COEF_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire rdm_pkg::rdm_req_t       req,
  input  wire rdm_pkg::rdm_cmd_t       cmd,
  output rdm_pkg::rdm_stat_t           st,
  output rdm_pkg::rdm_result_t         result,
  input  wire logic                    cfg_we,
  input  wire logic [rdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_WIDTH-1:0]   cfg_data
);
  localparam int CW = rdm_pkg::COORD_WIDTH;
  localparam int CF = COEF_WIDTH - 8;
  localparam logic signed [63:0] ONE  = 64'sd1 <<< CF;
  localparam logic signed [63:0] SMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] CMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] CMIN = -(64'sd1 <<< (CW - 1));

  logic signed [COEF_WIDTH-1:0] k1, k2, k3;
  logic [rdm_pkg::TOL_WIDTH-1:0] tol;
  logic [rdm_pkg::LIM_WIDTH-1:0] lim, cnt;

  logic signed [CW-1:0] px, py, xt, yt, xp, yp, rx, ry;
  logic signed [63:0]   r2, r4, r6, s;
  logic                 inv, have_prev;
  logic [1:0]           status;

  logic signed [63:0] ma, mb, mprod, add_a, add_s;
  logic               mfrac, mdone, ddone;
  logic signed [CW-1:0] dnum, dquo;
  logic signed [CW:0]   dx, dy;
  logic [CW:0]          adx, ady;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      k1  <= '0;
      k2  <= '0;
      k3  <= '0;
      tol <= rdm_pkg::TOL_RESET;
      lim <= rdm_pkg::LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rdm_pkg::REG_K1:  k1  <= cfg_data;
        rdm_pkg::REG_K2:  k2  <= cfg_data;
        rdm_pkg::REG_K3:  k3  <= cfg_data;
        rdm_pkg::REG_TOL: tol <= cfg_data[rdm_pkg::TOL_WIDTH-1:0];
        rdm_pkg::REG_LIM: lim <= cfg_data[rdm_pkg::LIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Multiplier operands
  always_comb begin
    mfrac = 1'b0;
    case (cmd.mop)
      rdm_pkg::MOP_XX: begin ma = 64'(xt); mb = 64'(xt); end
      rdm_pkg::MOP_YY: begin ma = 64'(yt); mb = 64'(yt); end
      rdm_pkg::MOP_R4: begin ma = r2; mb = r2; end
      rdm_pkg::MOP_R6: begin ma = r4; mb = r2; end
      rdm_pkg::MOP_K1: begin ma = 64'(k1); mb = r2; end
      rdm_pkg::MOP_K2: begin ma = 64'(k2); mb = r4; end
      rdm_pkg::MOP_K3: begin ma = 64'(k3); mb = r6; end
      rdm_pkg::MOP_FX: begin ma = 64'(px); mb = s; mfrac = 1'b1; end
      rdm_pkg::MOP_FY: begin ma = 64'(py); mb = s; mfrac = 1'b1; end
      default:         begin ma = '0; mb = '0; end
    endcase
  end

  rdm_mul #(.COEF_WIDTH(COEF_WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .a(ma), .b(mb),
    .frac_coef(mfrac), .done(mdone), .prod(mprod)
  );

  assign dnum = cmd.div_y ? py : px;

  rdm_div #(.COEF_WIDTH(COEF_WIDTH)) u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .num(dnum), .den(s),
    .done(ddone), .quo(dquo)
  );

  // Saturating accumulate for r2 and the scale
  always_comb begin
    case (cmd.mop)
      rdm_pkg::MOP_YY: add_a = r2;
      rdm_pkg::MOP_K1: add_a = ONE;
      default:         add_a = s;
    endcase
    add_s = add_a + mprod;
    if (!add_a[63] && !mprod[63] && add_s[63]) add_s = SMAX;
    else if (add_a[63] && mprod[63] && !add_s[63]) add_s = SMIN;
  end

  // Convergence test
  always_comb begin
    dx  = {xt[CW-1], xt} - {xp[CW-1], xp};
    dy  = {yt[CW-1], yt} - {yp[CW-1], yp};
    adx = dx[CW] ? (~dx + (CW+1)'(1)) : dx;
    ady = dy[CW] ? (~dy + (CW+1)'(1)) : dy;
  end

  assign st.mul_done   = mdone;
  assign st.div_done   = ddone;
  assign st.scale_zero = (s == 64'sd0);
  assign st.inverse    = inv;
  assign st.converged  = have_prev && (adx <= (CW+1)'(tol)) && (ady <= (CW+1)'(tol));
  assign st.last_pass  = (cnt + 8'd1) == lim;
  assign st.lim_zero   = (lim == '0);

  always_ff @(posedge clk) begin
    // Item load
    if (cmd.load) begin
      px        <= req.point_x;
      py        <= req.point_y;
      xt        <= req.point_x;
      yt        <= req.point_y;
      inv       <= req.req_type;
      rx        <= '0;
      ry        <= '0;
      cnt       <= '0;
      have_prev <= 1'b0;
      status    <= req.req_type ? rdm_pkg::STAT_NOCONVERGE : rdm_pkg::STAT_OK;
    end
    // Multiplier writeback
    if (cmd.mul_wb) begin
      case (cmd.mop)
        rdm_pkg::MOP_XX: r2 <= mprod;
        rdm_pkg::MOP_YY: r2 <= add_s;
        rdm_pkg::MOP_R4: r4 <= mprod;
        rdm_pkg::MOP_R6: r6 <= mprod;
        rdm_pkg::MOP_FX: rx <= (mprod > CMAX) ? CMAX[CW-1:0] :
                               (mprod < CMIN) ? CMIN[CW-1:0] : mprod[CW-1:0];
        rdm_pkg::MOP_FY: ry <= (mprod > CMAX) ? CMAX[CW-1:0] :
                               (mprod < CMIN) ? CMIN[CW-1:0] : mprod[CW-1:0];
        default:         s  <= add_s;
      endcase
    end
    // Divider writeback
    if (cmd.div_wb) begin
      if (cmd.div_y) yt <= dquo;
      else xt <= dquo;
    end
    // End of an inverse pass
    if (cmd.step) begin
      xp        <= xt;
      yp        <= yt;
      have_prev <= 1'b1;
      cnt       <= cnt + 8'd1;
      if (st.converged) begin
        status <= rdm_pkg::STAT_OK;
        rx     <= xt;
        ry     <= yt;
      end
    end
    if (cmd.set_zero) status <= rdm_pkg::STAT_ZERO;
  end

  assign result.result_x = rx;
  assign result.result_y = ry;
  assign result.status   = status;
endmodule
`default_nettype wire

[rtl/rdm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: steps the datapath through the scale polynomial, the
// forward products or the inverse divisions and the convergence test.
module rdm_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               req_type,
  input  wire rdm_pkg::rdm_stat_t st,
  output rdm_pkg::rdm_cmd_t       cmd,
  output logic                    busy,
  output logic                    done
);
  rdm_pkg::rdm_state_t state, state_next;
  logic issued, issued_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rdm_pkg::ST_IDLE;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
    end
  end

  always_comb begin
    state_next  = state;
    issued_next = issued;
    cmd         = '0;
    cmd.mop     = rdm_pkg::MOP_XX;
    busy        = 1'b1;
    done        = 1'b0;
    case (state)
      rdm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (req_type && st.lim_zero) ? rdm_pkg::ST_DONE : rdm_pkg::ST_SQX;
        end
      end
      rdm_pkg::ST_SQX, rdm_pkg::ST_SQY, rdm_pkg::ST_R4, rdm_pkg::ST_R6,
      rdm_pkg::ST_K1, rdm_pkg::ST_K2, rdm_pkg::ST_K3,
      rdm_pkg::ST_FWDX, rdm_pkg::ST_FWDY: begin
        case (state)
          rdm_pkg::ST_SQX:  cmd.mop = rdm_pkg::MOP_XX;
          rdm_pkg::ST_SQY:  cmd.mop = rdm_pkg::MOP_YY;
          rdm_pkg::ST_R4:   cmd.mop = rdm_pkg::MOP_R4;
          rdm_pkg::ST_R6:   cmd.mop = rdm_pkg::MOP_R6;
          rdm_pkg::ST_K1:   cmd.mop = rdm_pkg::MOP_K1;
          rdm_pkg::ST_K2:   cmd.mop = rdm_pkg::MOP_K2;
          rdm_pkg::ST_K3:   cmd.mop = rdm_pkg::MOP_K3;
          rdm_pkg::ST_FWDX: cmd.mop = rdm_pkg::MOP_FX;
          default:          cmd.mop = rdm_pkg::MOP_FY;
        endcase
        if (!issued) begin
          cmd.mul_start = 1'b1;
          issued_next   = 1'b1;
        end else if (st.mul_done) begin
          cmd.mul_wb  = 1'b1;
          issued_next = 1'b0;
          case (state)
            rdm_pkg::ST_SQX:  state_next = rdm_pkg::ST_SQY;
            rdm_pkg::ST_SQY:  state_next = rdm_pkg::ST_R4;
            rdm_pkg::ST_R4:   state_next = rdm_pkg::ST_R6;
            rdm_pkg::ST_R6:   state_next = rdm_pkg::ST_K1;
            rdm_pkg::ST_K1:   state_next = rdm_pkg::ST_K2;
            rdm_pkg::ST_K2:   state_next = rdm_pkg::ST_K3;
            rdm_pkg::ST_K3:   state_next = rdm_pkg::ST_CHKS;
            rdm_pkg::ST_FWDX: state_next = rdm_pkg::ST_FWDY;
            default:          state_next = rdm_pkg::ST_DONE;
          endcase
        end
      end
      // Zero scale ends either request with a fault
      rdm_pkg::ST_CHKS: begin
        if (st.scale_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = rdm_pkg::ST_DONE;
        end else begin
          state_next = st.inverse ? rdm_pkg::ST_DIVX : rdm_pkg::ST_FWDX;
        end
      end
      rdm_pkg::ST_DIVX, rdm_pkg::ST_DIVY: begin
        cmd.div_y = (state == rdm_pkg::ST_DIVY);
        if (!issued) begin
          cmd.div_start = 1'b1;
          issued_next   = 1'b1;
        end else if (st.div_done) begin
          cmd.div_wb  = 1'b1;
          issued_next = 1'b0;
          state_next  = (state == rdm_pkg::ST_DIVX) ? rdm_pkg::ST_DIVY : rdm_pkg::ST_CONV;
        end
      end
      rdm_pkg::ST_CONV: begin
        cmd.step = 1'b1;
        if (st.converged || st.last_pass) state_next = rdm_pkg::ST_DONE;
        else state_next = rdm_pkg::ST_SQX;
      end
      rdm_pkg::ST_DONE: begin
        done       = 1'b1;
        state_next = rdm_pkg::ST_IDLE;
      end
      default: state_next = rdm_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[rtl/radial_distortion_map.sv]
`timescale 1ns / 1ps
`default_nettype none
// Three-term radial lens distortion map, Q8.24 coordinates, Q8.40 coefficients.
// Input: raise start with req (type and point) while busy is low; the beat is
// taken at that edge and busy rises on the next cycle.
// Output: done is high for exactly one cycle with result valid; it cannot be
// held off, so a receiver must take it in that cycle.
// Configuration: cfg_we/cfg_index/cfg_data write one register per edge; the user
// must write only while busy is low, the block itself does not enforce it.
// Datapath: one shared 64x64 multiplier (4 partial products plus a finalize
// step) and one restoring divider (one quotient bit per cycle).
// Forward request: 9 products plus the scale check.
// Inverse request: per pass 7 products, the scale check, 2 divisions and the
// convergence step, up to iteration_limit passes.
// One item at a time; the next start is taken the cycle after done.
// Reset: synchronous; clears the sequencer and loads the register defaults
// (coefficients zero, tolerance 17, limit 50).
module radial_distortion_map #(
  parameter int COEF_WIDTH = rdm_pkg::COEF_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire rdm_pkg::rdm_req_t                req,
  output logic                                  busy,
  output logic                                  done,
  output rdm_pkg::rdm_result_t                  result,
  input  wire logic                             cfg_we,
  input  wire logic [rdm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [COEF_WIDTH-1:0]            cfg_data
);
  rdm_pkg::rdm_cmd_t  cmd;
  rdm_pkg::rdm_stat_t st;

  rdm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .req_type(req.req_type),
    .st(st), .cmd(cmd), .busy(busy), .done(done)
  );

  rdm_datapath #(.COEF_WIDTH(COEF_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .req(req), .cmd(cmd), .st(st), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );
endmodule
`default_nettype wire
